FILE: design/b64d_pkg.sv
// Shared types, constants and the character map of the base64url decoder.
package b64d_pkg;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Characters with a meaning of their own
    localparam logic [7:0] PAD_CHAR        = 8'd61;  // '='
    localparam logic [7:0] CHAR_DASH       = 8'd45;  // '-'
    localparam logic [7:0] CHAR_UNDERSCORE = 8'd95;  // '_'
    localparam logic [7:0] CHAR_UPPER_A    = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'd90;
    localparam logic [7:0] CHAR_LOWER_A    = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'd122;
    localparam logic [7:0] CHAR_DIGIT_0    = 8'd48;
    localparam logic [7:0] CHAR_DIGIT_9    = 8'd57;

    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_DASH       = 6'd62;
    localparam logic [5:0] SEXTET_UNDERSCORE = 6'd63;

    // Byte count codes of a job; status-only means one result with no byte
    localparam logic [1:0] NBYTES_STATUS = 2'd0;
    localparam logic [1:0] NBYTES_ONE    = 2'd1;
    localparam logic [1:0] NBYTES_TWO    = 2'd2;
    localparam logic [1:0] NBYTES_THREE  = 2'd3;

    // Decoded character: bad set when outside the alphabet (value then zero)
    typedef struct packed {
        logic       bad;
        logic [5:0] val;
    } sextet_t;

    // One decoded group or end-of-text status, handed from front to back
    typedef struct packed {
        logic [2:0][7:0] bytes;   // bytes[0] goes out first
        logic [1:0]      nbytes;  // NBYTES_STATUS: one result without a byte
        logic            done;    // text ends with this job
        logic            err;     // error flag for a status-only job
    } job_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.bad = 1'b0;
        s.val = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            s.val = 6'(c - CHAR_UPPER_A);
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            s.val = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
            s.val = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
        else if (c == CHAR_DASH)
            s.val = SEXTET_DASH;
        else if (c == CHAR_UNDERSCORE)
            s.val = SEXTET_UNDERSCORE;
        else
            s.bad = 1'b1;
        return s;
    endfunction

endpackage

FILE: design/b64d_front.sv
// Front end: accepts characters, tracks the group and builds decode jobs.
module b64d_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        char_code,
    input  logic              last_char,
    input  logic              empty_text,
    output logic              job_valid,
    output b64d_pkg::job_t    job,
    input  logic              job_ready
);

    logic [1:0] pos_reg, pos_next;
    logic       failed_reg, failed_next;
    logic [7:0] held_reg [3];

    logic            accept;
    logic            emit;
    b64d_pkg::job_t  job_c;
    b64d_pkg::sextet_t s0, s1, s2, s3;
    logic            all_good;
    logic            held_wr;

    // Accept only while the queue has a free slot
    assign in_ready = job_ready;
    assign accept   = in_valid & in_ready;

    assign s0 = b64d_pkg::sextet_of(held_reg[0]);
    assign s1 = b64d_pkg::sextet_of(held_reg[1]);
    assign s2 = b64d_pkg::sextet_of(held_reg[2]);
    assign s3 = b64d_pkg::sextet_of(char_code);
    assign all_good = ~(s0.bad | s1.bad | s2.bad | s3.bad);

    // Classify the character and build the job
    always_comb
    begin
        emit          = 1'b0;
        pos_next      = pos_reg;
        failed_next   = failed_reg;
        held_wr       = 1'b0;
        job_c         = '0;
        job_c.bytes[0] = {s0.val, s1.val[5:4]};
        job_c.bytes[1] = {s1.val[3:0], s2.val[5:2]};
        job_c.bytes[2] = {s2.val[1:0], s3.val};
        job_c.nbytes  = b64d_pkg::NBYTES_STATUS;
        job_c.done    = last_char;
        job_c.err     = 1'b0;

        if (empty_text)
        begin
            emit        = 1'b1;
            job_c.done  = 1'b1;
            job_c.err   = failed_reg | (pos_reg != 2'd0);
            pos_next    = 2'd0;
            failed_next = 1'b0;
        end
        else if (failed_reg)
        begin
            // skip characters until the text ends
            if (last_char)
            begin
                emit        = 1'b1;
                job_c.err   = 1'b1;
                pos_next    = 2'd0;
                failed_next = 1'b0;
            end
        end
        else if (pos_reg != 2'd3)
        begin
            held_wr  = 1'b1;
            pos_next = pos_reg + 2'd1;
            // text ends inside a group
            if (last_char)
            begin
                emit      = 1'b1;
                job_c.err = 1'b1;
                pos_next  = 2'd0;
            end
        end
        else
        begin
            // fourth character completes the group
            pos_next = 2'd0;
            if (!last_char)
            begin
                if (all_good)
                begin
                    emit         = 1'b1;
                    job_c.nbytes = b64d_pkg::NBYTES_THREE;
                end
                else
                    failed_next = 1'b1;
            end
            else
            begin
                emit = 1'b1;
                if (!s0.bad && !s1.bad && held_reg[2] == b64d_pkg::PAD_CHAR
                    && char_code == b64d_pkg::PAD_CHAR)
                    job_c.nbytes = b64d_pkg::NBYTES_ONE;
                else if (!s0.bad && !s1.bad && !s2.bad
                         && char_code == b64d_pkg::PAD_CHAR)
                    job_c.nbytes = b64d_pkg::NBYTES_TWO;
                else if (all_good)
                    job_c.nbytes = b64d_pkg::NBYTES_THREE;
                else
                    job_c.err = 1'b1;
                failed_next = 1'b0;
            end
        end
    end

    assign job_valid = accept & emit;
    assign job       = job_c;

    // Group and failure state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 2'd0;
            failed_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            failed_reg <= failed_next;
        end
    end

    // Held characters of the open group
    always_ff @(posedge clk)
    begin
        if (accept && held_wr)
            held_reg[pos_reg] <= char_code;
    end

endmodule

FILE: design/b64d_queue.sv
// Small job queue between the front and back ends.
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  b64d_pkg::job_t    push_job,
    output logic              pop_valid,
    input  logic              pop_ready,
    output b64d_pkg::job_t    pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::job_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              wr, rd;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign wr         = push_valid & push_ready;
    assign rd         = pop_valid & pop_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (wr && !rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (rd && !wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: design/b64d_back.sv
// Back end: splits each job into result requests behind an output register.
module b64d_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  b64d_pkg::job_t    job,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              out_byte_valid,
    output logic              out_done,
    output logic              out_err
);

    b64d_pkg::job_t cur_reg;
    logic           cur_valid_reg;
    logic [1:0]     idx_reg;

    logic           out_valid_reg;
    logic [7:0]     out_byte_reg;
    logic           out_bvalid_reg;
    logic           out_done_reg;
    logic           out_err_reg;

    logic           load_out;
    logic           status_only;
    logic           last_of_job;
    logic           take;

    assign status_only = (cur_reg.nbytes == b64d_pkg::NBYTES_STATUS);
    assign last_of_job = status_only | ((idx_reg + 2'd1) == cur_reg.nbytes);
    assign load_out    = cur_valid_reg & (~out_valid_reg | out_ready);
    assign take        = job_valid & (~cur_valid_reg | (load_out & last_of_job));
    assign job_ready   = take;

    // Current job and byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (load_out)
            begin
                if (last_of_job)
                    cur_valid_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cur_reg <= job;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (status_only)
            begin
                out_byte_reg   <= 8'd0;
                out_bvalid_reg <= 1'b0;
                out_done_reg   <= 1'b1;
                out_err_reg    <= cur_reg.err;
            end
            else
            begin
                out_byte_reg   <= cur_reg.bytes[idx_reg];
                out_bvalid_reg <= 1'b1;
                out_done_reg   <= cur_reg.done & last_of_job;
                out_err_reg    <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_byte_valid = out_bvalid_reg;
    assign out_done       = out_done_reg;
    assign out_err        = out_err_reg;

endmodule

FILE: design/base64url_stream_decoder.sv
// Top level of the streaming base64url decoder.
// Usage:
//   Input stream: one character per request; tdata = character byte,
//   tlast = last character of the text, tuser = empty-text marker (the
//   request carries no character and closes the text).
//   Output stream: one decoded byte per request; tdata = byte, tlast = final
//   result of the text, tuser[0] = byte present, tuser[1] = malformed text.
//   A text that ends without bytes (empty, or malformed) gives one request
//   with tuser[0] low and tlast high.
// Timing:
//   One character is taken every cycle while the queue has room. The front
//   end classifies it and pushes a job into a job queue; the back end
//   drains the queue one output request per cycle, while the receiver is
//   ready, from its output register. Bar empty texts, no input request
//   makes more outputs than the characters it closes: the back end keeps up.
// Reset clears the group position, failure mark, queue and output register.
// When the receiver stalls the output register holds, the queue fills
// (QUEUE_DEPTH jobs), and s_axis_tready then drops until a slot frees.
module base64url_stream_decoder #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,   // last_char
    input  logic       s_axis_tuser,   // empty_text
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tlast,   // done_res
    output logic [1:0] m_axis_tuser    // [0] byte_valid, [1] error
);

    logic           push_valid, push_ready;
    b64d_pkg::job_t push_job;
    logic           pop_valid, pop_ready;
    b64d_pkg::job_t pop_job;
    logic           bvalid, err;

    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .char_code  (s_axis_tdata),
        .last_char  (s_axis_tlast),
        .empty_text (s_axis_tuser),
        .job_valid  (push_valid),
        .job        (push_job),
        .job_ready  (push_ready)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    b64d_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (pop_valid),
        .job_ready      (pop_ready),
        .job            (pop_job),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_byte       (m_axis_tdata),
        .out_byte_valid (bvalid),
        .out_done       (m_axis_tlast),
        .out_err        (err)
    );

    assign m_axis_tuser = {err, bvalid};

endmodule
